@@ src/mrd_pkg.sv @@
// Shared types and codes for the multi-digit restoring divider.
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

  // Kind of digit pass the datapath runs for an issued element
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_ALIGN = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_we;    // write the input digit pair at addr
    logic       load_first; // first digit of an operand: restart bit-length tracking
    logic       setup;      // latch shift amounts, step count and special cases
    logic       issue;      // an element of a digit pass is read this cycle
    logic [1:0] mode;       // pass kind of the issued element
    logic       first;      // first element of the pass
    logic       elem_last;  // element is the most significant digit
    logic       q_init;     // first bit step: old quotient reads as zero
    logic       step_done;  // one bit step finished
    logic       out_load;   // load the result register from the read data
    logic       out_last;   // result being loaded is the most significant one
  } mrd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic do_div;    // divisor non-zero and dividend not below it
    logic last_step; // the current bit step is the final one
    logic out_free;  // result register can take a new result this cycle
  } mrd_sts_t;

endpackage

`default_nettype wire

@@ src/mrd_datapath.sv @@
// Datapath of the divider: operand memories, digit-serial arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none

module mrd_datapath #(
  parameter int MAX_DIGITS = 64,
  parameter int DIGIT_BITS = 32,
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mrd_pkg::mrd_cmd_t     cmd,
  input  wire logic [IDX_W-1:0]      addr,
  input  wire logic [DIGIT_BITS-1:0] dividend_digit,
  input  wire logic [DIGIT_BITS-1:0] divisor_digit,
  output mrd_pkg::mrd_sts_t          sts,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [DIGIT_BITS-1:0]      quotient_digit,
  output logic [DIGIT_BITS-1:0]      remainder_digit,
  output logic                       status,
  output logic                       last_result
);
  import mrd_pkg::*;

  localparam int BL_W   = $clog2(DIGIT_BITS + 1);
  localparam int BPOS_W = $clog2(DIGIT_BITS);
  localparam int STEP_W = $clog2(MAX_DIGITS * DIGIT_BITS + 1);

  // Number of significant bits of one digit
  function automatic logic [BL_W-1:0] bit_len(input logic [DIGIT_BITS-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      if (v[k]) n = BL_W'(k + 1);
    end
    return n;
  endfunction

  // Operand memories
  logic [DIGIT_BITS-1:0] r_mem [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] d_mem [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] q_mem [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] r_rd_r, q_rd_r, da_rd_r, db_rd_r;

  // Top-digit tracking while loading
  logic             a_nz_r, a_nz_nxt, b_nz_r, b_nz_nxt;
  logic [IDX_W-1:0] a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;
  logic [BL_W-1:0]  a_len_r, a_len_nxt, b_len_r, b_len_nxt;

  // Values latched at setup
  logic              div_zero_r, do_div_r, q_live_r;
  logic [IDX_W-1:0]  sh_w_r, sh_w_nxt;
  logic [BPOS_W-1:0] sh_b_r, sh_b_nxt;
  logic [STEP_W-1:0] steps_left_r, steps_nxt;
  logic              a_ge_b, len_ge;

  // Read addressing
  logic [IDX_W-1:0] da_addr, db_addr;
  logic             da_ok, db_ok;

  // Read stage
  logic             p1_valid_r, p1_first_r, p1_qinit_r, p1_daok_r, p1_dbok_r;
  logic [1:0]       p1_mode_r;
  logic [IDX_W-1:0] p1_addr_r;

  // Update stage
  logic                  is_step, is_align, ge_now, bin, borrow, q_in;
  logic [DIGIT_BITS-1:0] sub_val, new_r, old_q, new_q, new_d_step, new_d_align;
  logic [DIGIT_BITS-1:0] al_hi, al_lo;
  logic [DIGIT_BITS:0]   diff;
  logic                  brw_r, qc_r, cur_ge_r;

  // Memory write port
  logic [IDX_W-1:0]      wr_addr;
  logic                  r_we, d_we, q_we;
  logic [DIGIT_BITS-1:0] r_wdata, d_wdata;

  // Compare stage
  logic                  s2_valid_r, s2_first_r;
  logic [1:0]            s2_mode_r;
  logic [DIGIT_BITS-1:0] s2_a_r, s2_b_r;
  logic                  cmp_ge_r, cmp_ge_nxt, cmp_dec_r, cmp_dec_nxt, ge_in, dec_in;

  // Result register
  logic                  out_valid_r, out_st_r, out_last_r;
  logic [DIGIT_BITS-1:0] out_q_r, out_rm_r;

  // Track the most significant non-zero digit of each operand
  always_comb begin
    a_nz_nxt  = a_nz_r;
    a_idx_nxt = a_idx_r;
    a_len_nxt = a_len_r;
    b_nz_nxt  = b_nz_r;
    b_idx_nxt = b_idx_r;
    b_len_nxt = b_len_r;
    if (cmd.load_we) begin
      if (cmd.load_first) begin
        a_nz_nxt = 1'b0;
        b_nz_nxt = 1'b0;
      end
      if (dividend_digit != '0) begin
        a_nz_nxt  = 1'b1;
        a_idx_nxt = addr;
        a_len_nxt = bit_len(dividend_digit);
      end
      if (divisor_digit != '0) begin
        b_nz_nxt  = 1'b1;
        b_idx_nxt = addr;
        b_len_nxt = bit_len(divisor_digit);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_nz_r  <= a_nz_nxt;
    a_idx_r <= a_idx_nxt;
    a_len_r <= a_len_nxt;
    b_nz_r  <= b_nz_nxt;
    b_idx_r <= b_idx_nxt;
    b_len_r <= b_len_nxt;
  end

  // Alignment shift split into whole digits and bits, and the bit-step count
  always_comb begin
    len_ge = a_len_r >= b_len_r;
    a_ge_b = a_nz_r && ((a_idx_r > b_idx_r) || ((a_idx_r == b_idx_r) && len_ge));
    if (len_ge) begin
      sh_w_nxt = a_idx_r - b_idx_r;
      sh_b_nxt = BPOS_W'(a_len_r - b_len_r);
    end else begin
      sh_w_nxt = a_idx_r - b_idx_r - 1'b1;
      sh_b_nxt = BPOS_W'({1'b0, a_len_r} + (BL_W + 1)'(DIGIT_BITS) - {1'b0, b_len_r});
    end
    steps_nxt = STEP_W'(sh_w_nxt * DIGIT_BITS) + STEP_W'(sh_b_nxt) + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      div_zero_r   <= !b_nz_r;
      do_div_r     <= b_nz_r && a_ge_b;
      sh_w_r       <= sh_w_nxt;
      sh_b_r       <= sh_b_nxt;
      steps_left_r <= steps_nxt;
      q_live_r     <= 1'b0;
    end else begin
      if (cmd.step_done) steps_left_r <= steps_left_r - 1'b1;
      if (is_step) q_live_r <= 1'b1;
    end
  end

  // Divisor read addresses: shifted source digits when aligning, i and i+1 in a bit step
  always_comb begin
    da_addr = addr;
    db_addr = addr + 1'b1;
    da_ok   = 1'b1;
    db_ok   = !cmd.elem_last;
    unique case (cmd.mode)
      MODE_ALIGN: begin
        da_addr = addr - sh_w_r;
        db_addr = addr - sh_w_r - 1'b1;
        da_ok   = addr >= sh_w_r;
        db_ok   = addr > sh_w_r;
      end
      MODE_STEP: begin
      end
      MODE_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (r_we) r_mem[wr_addr] <= r_wdata;
    r_rd_r <= r_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[wr_addr] <= new_q;
    q_rd_r <= q_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (d_we) d_mem[wr_addr] <= d_wdata;
    da_rd_r <= d_mem[da_addr];
    db_rd_r <= d_mem[db_addr];
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= cmd.issue;
    end
    p1_mode_r  <= cmd.mode;
    p1_first_r <= cmd.first;
    p1_qinit_r <= cmd.q_init;
    p1_addr_r  <= addr;
    p1_daok_r  <= da_ok;
    p1_dbok_r  <= db_ok;
  end

  // Update stage: subtract, shift quotient in, shift divisor right; or align divisor
  always_comb begin
    is_step     = p1_valid_r && (p1_mode_r == MODE_STEP);
    is_align    = p1_valid_r && (p1_mode_r == MODE_ALIGN);
    ge_now      = p1_first_r ? cmp_ge_r : cur_ge_r;
    sub_val     = ge_now ? da_rd_r : '0;
    bin         = p1_first_r ? 1'b0 : brw_r;
    diff        = {1'b0, r_rd_r} - {1'b0, sub_val} - {{DIGIT_BITS{1'b0}}, bin};
    new_r       = diff[DIGIT_BITS-1:0];
    borrow      = diff[DIGIT_BITS];
    old_q       = p1_qinit_r ? '0 : q_rd_r;
    q_in        = p1_first_r ? ge_now : qc_r;
    new_q       = {old_q[DIGIT_BITS-2:0], q_in};
    new_d_step  = {p1_dbok_r & db_rd_r[0], da_rd_r[DIGIT_BITS-1:1]};
    al_hi       = p1_daok_r ? (da_rd_r << sh_b_r) : '0;
    al_lo       = (p1_dbok_r && (sh_b_r != '0)) ?
                  (db_rd_r >> (DIGIT_BITS - int'(sh_b_r))) : '0;
    new_d_align = al_hi | al_lo;
  end

  // Write port: loading has the port to itself
  always_comb begin
    wr_addr = cmd.load_we ? addr : p1_addr_r;
    r_we    = cmd.load_we || is_step;
    d_we    = cmd.load_we || is_step || is_align;
    q_we    = is_step;
    r_wdata = cmd.load_we ? dividend_digit : new_r;
    d_wdata = cmd.load_we ? divisor_digit : (is_step ? new_d_step : new_d_align);
  end

  // Carries between digits of a bit step
  always_ff @(posedge clk) begin
    if (is_step) begin
      brw_r <= borrow;
      qc_r  <= old_q[DIGIT_BITS-1];
      if (p1_first_r) cur_ge_r <= ge_now;
    end
  end

  // Compare stage inputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= is_step || is_align;
    end
    s2_mode_r  <= p1_mode_r;
    s2_first_r <= p1_first_r;
    s2_a_r     <= is_step ? new_r : r_rd_r;
    s2_b_r     <= is_step ? new_d_step : new_d_align;
  end

  // Remainder against divisor: low digits first in a bit step, high first when aligning
  always_comb begin
    cmp_ge_nxt  = cmp_ge_r;
    cmp_dec_nxt = cmp_dec_r;
    ge_in       = s2_first_r || cmp_ge_r;
    dec_in      = !s2_first_r && cmp_dec_r;
    if (s2_valid_r) begin
      if (s2_mode_r == MODE_STEP) begin
        cmp_ge_nxt = (s2_a_r > s2_b_r) || ((s2_a_r == s2_b_r) && ge_in);
      end else if (dec_in) begin
        cmp_dec_nxt = 1'b1;
      end else begin
        cmp_ge_nxt  = (s2_a_r != s2_b_r) ? (s2_a_r > s2_b_r) : 1'b1;
        cmp_dec_nxt = s2_a_r != s2_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_ge_r  <= cmp_ge_nxt;
    cmp_dec_r <= cmp_dec_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_q_r    <= (div_zero_r || !q_live_r) ? '0 : q_rd_r;
      out_rm_r   <= div_zero_r ? '0 : r_rd_r;
      out_st_r   <= div_zero_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.do_div    = do_div_r;
  assign sts.last_step = steps_left_r == STEP_W'(1);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign quotient_digit  = out_q_r;
  assign remainder_digit = out_rm_r;
  assign status          = out_st_r;
  assign last_result     = out_last_r;

endmodule

`default_nettype wire

@@ src/mrd_ctrl.sv @@
// Controller of the divider: load, alignment, bit-step passes and result sequencing.
`timescale 1ns / 1ps
`default_nettype none

module mrd_ctrl #(
  parameter int MAX_DIGITS = 64,
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire mrd_pkg::mrd_sts_t sts,
  output mrd_pkg::mrd_cmd_t      cmd,
  output logic [IDX_W-1:0]       addr
);
  import mrd_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ALIGN  = 3'd3;
  localparam logic [2:0] S_STEP   = 3'd4;
  localparam logic [2:0] S_GAP    = 3'd5;
  localparam logic [2:0] S_OUT_RD = 3'd6;
  localparam logic [2:0] S_OUT_LD = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt, last_idx_r, last_idx_nxt;
  logic             gap_r, gap_nxt;
  logic             from_align_r, from_align_nxt;
  logic             first_step_r, first_step_nxt;
  logic             at_max, at_last;

  assign at_max  = cnt_r == IDX_W'(MAX_DIGITS - 1);
  assign at_last = cnt_r == last_idx_r;
  assign addr    = cnt_r;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    last_idx_nxt   = last_idx_r;
    gap_nxt        = gap_r;
    from_align_nxt = from_align_r;
    first_step_nxt = first_step_r;
    cmd            = '0;
    cmd.mode       = MODE_NONE;
    in_ready       = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_we    = 1'b1;
          cmd.load_first = cnt_r == '0;
          if (in_last || at_max) begin
            last_idx_nxt = cnt_r;
            cnt_nxt      = '0;
            state_nxt    = S_SETUP;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.do_div) begin
          cnt_nxt        = last_idx_r;
          first_step_nxt = 1'b1;
          state_nxt      = S_ALIGN;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_OUT_RD;
        end
      end
      // Top digit first, so the shifted divisor only reads digits not yet rewritten
      S_ALIGN: begin
        cmd.issue = 1'b1;
        cmd.mode  = MODE_ALIGN;
        cmd.first = at_last;
        if (cnt_r == '0) begin
          from_align_nxt = 1'b1;
          gap_nxt        = 1'b0;
          state_nxt      = S_GAP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_STEP: begin
        cmd.issue     = 1'b1;
        cmd.mode      = MODE_STEP;
        cmd.first     = cnt_r == '0;
        cmd.elem_last = at_last;
        cmd.q_init    = first_step_r;
        if (at_last) begin
          from_align_nxt = 1'b0;
          gap_nxt        = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_GAP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // Drain the update and compare stages before the next pass
      S_GAP: begin
        if (!gap_r) begin
          gap_nxt = 1'b1;
        end else begin
          cnt_nxt = '0;
          if (from_align_r) begin
            state_nxt = S_STEP;
          end else begin
            cmd.step_done  = 1'b1;
            first_step_nxt = 1'b0;
            state_nxt      = sts.last_step ? S_OUT_RD : S_STEP;
          end
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = at_last;
          if (at_last) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      cnt_r        <= '0;
      last_idx_r   <= '0;
      gap_r        <= 1'b0;
      from_align_r <= 1'b0;
      first_step_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      last_idx_r   <= last_idx_nxt;
      gap_r        <= gap_nxt;
      from_align_r <= from_align_nxt;
      first_step_r <= first_step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/multiword_restoring_divider_top.sv @@
// Top level of the multi-digit restoring divider.
`timescale 1ns / 1ps
`default_nettype none

// Unsigned multi-digit divider. Operands arrive as transfers of one dividend
// digit and one divisor digit, least significant first, one transfer per cycle
// while loading (in_tready is low while a division runs); tlast (or the
// MAX_DIGITS-th digit) closes the operands and starts the division. The block
// then runs setup, aligns the divisor under the dividend, and runs one bit
// step for each of the (bits(dividend) - bits(divisor) + 1) quotient bits;
// every bit step walks the remainder, divisor and quotient memories one digit
// per cycle through their single write port. Results follow, least significant
// first, each once the output register is free, with quotient and remainder
// digits side by side; a zero divisor gives status 1 and zero digits. When
// there is nothing to subtract (divisor zero or larger than the dividend) the
// bit steps are skipped. The next operand is taken as soon as the last result
// sits in the output register. The memories need no clearing after reset.
module multiword_restoring_divider_top #(
  parameter int MAX_DIGITS = 64,
  parameter int DIGIT_BITS = 32,
  localparam int TDATA_W = ((2 * DIGIT_BITS + 7) / 8) * 8,
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // dividend_digit, divisor_digit
  input  wire logic               in_tlast,   // last_digit
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // quotient_digit, remainder_digit
  output logic                    out_tuser,  // status
  output logic                    out_tlast   // last_result
);
  import mrd_pkg::*;

  mrd_cmd_t              cmd;
  mrd_sts_t              sts;
  logic [IDX_W-1:0]      addr;
  logic [DIGIT_BITS-1:0] quo, rem;

  // Sequencing
  mrd_ctrl #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  // Storage and arithmetic
  mrd_datapath #(
    .MAX_DIGITS(MAX_DIGITS),
    .DIGIT_BITS(DIGIT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .dividend_digit  (in_tdata[DIGIT_BITS-1:0]),
    .divisor_digit   (in_tdata[2*DIGIT_BITS-1:DIGIT_BITS]),
    .sts             (sts),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .quotient_digit  (quo),
    .remainder_digit (rem),
    .status          (out_tuser),
    .last_result     (out_tlast)
  );

  assign out_tdata = TDATA_W'({rem, quo});

endmodule

`default_nettype wire

@@ test/tb_multiword_restoring_divider_top.sv @@
// Self-checking testbench for the multi-digit restoring divider top level.
`timescale 1ns / 1ps

module tb_multiword_restoring_divider_top;

  localparam int MAX_DIGITS = 64;
  localparam int DIGIT_W    = 32;
  localparam int SPAN       = MAX_DIGITS * DIGIT_W;
  localparam int NUM_ROWS   = 25;
  localparam int HOLD_OFF   = 400;  // long receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 200;  // settle time after the last result

  typedef logic [DIGIT_W-1:0] digit_t;

  // One result digit as the block should send it
  typedef struct packed {
    digit_t quotient;
    digit_t remainder;
    logic   status;
    logic   last;
  } result_t;

  // One row of the directed table; the typed answer is used only when typed is set
  typedef struct packed {
    digit_t dividend;
    digit_t divisor;
    logic   last;
    logic   typed;
    digit_t quotient;
    digit_t remainder;
    logic   status;
  } div_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [2*DIGIT_W-1:0]   in_tdata;   // dividend_digit, divisor_digit
  logic                   in_tlast;   // last_digit
  logic                   out_tvalid;
  logic                   out_tready;
  logic [2*DIGIT_W-1:0]   out_tdata;  // quotient_digit, remainder_digit
  logic                   out_tuser;  // status
  logic                   out_tlast;  // last_result

  digit_t   dividend_digits[$];
  digit_t   divisor_digits[$];
  result_t  pending_results[$];
  int       mismatch_count = 0;
  int       results_seen = 0;
  div_row_t div_table [NUM_ROWS];

  multiword_restoring_divider_top #(
    .MAX_DIGITS(MAX_DIGITS),
    .DIGIT_BITS(DIGIT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Report one mismatch on a line of its own and count it
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Full-width long division of the collected operand; one result per digit
  function automatic void divide_operand();
    logic [SPAN-1:0] num;
    logic [SPAN-1:0] den;
    logic [SPAN-1:0] quo;
    logic [SPAN-1:0] rmd;
    result_t         res;
    int              n;
    int              i;
    n   = dividend_digits.size();
    num = '0;
    den = '0;
    for (i = 0; i < n; i++) begin
      num[i*DIGIT_W +: DIGIT_W] = dividend_digits[i];
      den[i*DIGIT_W +: DIGIT_W] = divisor_digits[i];
    end
    // zero divisor: status set, all digits zero
    if (den == '0) begin
      quo = '0;
      rmd = '0;
    end else begin
      quo = num / den;
      rmd = num % den;
    end
    for (i = 0; i < n; i++) begin
      res.quotient  = quo[i*DIGIT_W +: DIGIT_W];
      res.remainder = rmd[i*DIGIT_W +: DIGIT_W];
      res.status    = (den == '0);
      res.last      = (i == n - 1);
      pending_results.push_back(res);
    end
  endfunction

  // Idle cycles before a transfer: mostly none or short, a few long
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Random digit with a spread of magnitudes and the extremes
  function automatic digit_t rand_digit();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return digit_t'(1) << $urandom_range(0, DIGIT_W - 1);
      3, 4, 5: return digit_t'($urandom()) >> $urandom_range(0, DIGIT_W - 1);
      default: return digit_t'($urandom());
    endcase
  endfunction

  // Offer one digit pair at the falling edge and hold it until the transfer.
  // Called at a falling edge, returns at a falling edge.
  task automatic send_digit(input digit_t dividend, input digit_t divisor, input bit last,
                            input bit burst, input bit typed, input result_t typed_res);
    int gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    // transfer taken: collect the digit, and divide once the operand closes
    dividend_digits.push_back(dividend);
    divisor_digits.push_back(divisor);
    if (last || dividend_digits.size() == MAX_DIGITS) begin
      if (typed) pending_results.push_back(typed_res);
      else divide_operand();
      dividend_digits.delete();
      divisor_digits.delete();
    end
    @(negedge clk);
  endtask

  // Operand of the full store width; the divisor's top digit is non-zero,
  // which keeps the bit loop short
  task automatic wide_operand(input bit close_with_last);
    int i;
    for (i = 0; i < MAX_DIGITS - 1; i++) begin
      send_digit(rand_digit(), rand_digit(), 1'b0, 1'b0, 1'b0, '0);
    end
    send_digit(digit_t'($urandom()), digit_t'($urandom()) | digit_t'(1), close_with_last,
               1'b0, 1'b0, '0);
  endtask

  // Random operand of mostly few digits, shaped to hit the special cases
  task automatic random_operand(inout int items);
    digit_t a [MAX_DIGITS];
    digit_t b [MAX_DIGITS];
    int     n;
    int     top_a;
    int     top_b;
    int     j;
    int     i;
    int     r;
    bit     burst;
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(1, 3) : (r < 93) ? $urandom_range(4, 8) :
        $urandom_range(9, 16);
    // dividend: zero above its top digit, and sometimes zero altogether
    top_a = $urandom_range(0, n - 1);
    for (i = 0; i < n; i++) begin
      a[i] = (i > top_a) ? '0 : rand_digit();
    end
    if ($urandom_range(0, 9) != 0 && a[top_a] == '0) a[top_a] = digit_t'($urandom()) | 1;
    for (i = 0; i < n; i++) b[i] = '0;
    j = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      // divide by zero
      0: ;
      // equal operands
      1: for (i = 0; i < n; i++) b[i] = a[i];
      // dividend just below the divisor
      2: begin
        for (i = 0; i < n; i++) b[i] = a[i];
        if (b[j] != '1) b[j] = b[j] + 1;
      end
      // dividend just above the divisor
      3: begin
        for (i = 0; i < n; i++) b[i] = a[i];
        if (b[j] != '0) b[j] = b[j] - 1;
      end
      // single-digit divisor
      4, 5: b[0] = rand_digit();
      // divisor of random length, not longer than the dividend
      6, 7: begin
        top_b = $urandom_range(0, top_a);
        for (i = 0; i <= top_b; i++) b[i] = rand_digit();
      end
      default: for (i = 0; i < n; i++) b[i] = rand_digit();
    endcase
    burst = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      send_digit(a[i], b[i], i == n - 1, burst, 1'b0, '0);
    end
    items += n;
  endtask

  // Result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with none expected: q=%h r=%h st=%b last=%b",
                                out_tdata[DIGIT_W-1:0], out_tdata[2*DIGIT_W-1:DIGIT_W],
                                out_tuser, out_tlast));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[DIGIT_W-1:0] !== want.quotient ||
            out_tdata[2*DIGIT_W-1:DIGIT_W] !== want.remainder ||
            out_tuser !== want.status || out_tlast !== want.last) begin
          flag_mismatch($sformatf(
            "result %0d: got q=%h r=%h st=%b last=%b, want q=%h r=%h st=%b last=%b",
            results_seen, out_tdata[DIGIT_W-1:0], out_tdata[2*DIGIT_W-1:DIGIT_W],
            out_tuser, out_tlast, want.quotient, want.remainder, want.status, want.last));
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int  stall_left;
    int  cycle;
    int  r;
    bit  burst;
    bit  held;
    stall_left = 0;
    cycle      = 0;
    burst      = 1'b0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 128 == 0) burst = ($urandom_range(0, 3) == 0);
      if (!held && results_seen >= 100) begin
        held       = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (!rst_n || stall_left > 0) begin
        out_tready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!burst) begin
          if (r >= 97) stall_left = $urandom_range(25, 60);
          else if (r >= 90) stall_left = $urandom_range(4, 12);
          else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int items;
    int k;
    result_t typed_res;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    // dividend, divisor, last, typed, quotient, remainder, status
    div_table = '{
      // single digit: divide by zero, zero dividend, below, equal, extremes
      '{32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h0000_0000, 32'h0000_0005, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{32'h0000_0007, 32'h0000_0009, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0007, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0010, 1'b1, 1'b1, 32'h0FFF_FFFF, 32'h0000_000F, 1'b0},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0},
      '{32'h0000_0064, 32'h0000_0007, 1'b1, 1'b1, 32'h0000_000E, 32'h0000_0002, 1'b0},
      '{32'h8000_0000, 32'h8000_0001, 1'b1, 1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0},
      // two digits of all ones by one
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
      // divide by zero over two digits
      '{32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
      // equal operands over three digits
      '{32'h89AB_CDEF, 32'h89AB_CDEF, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'h0123_4567, 32'h0123_4567, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'hF0F0_F0F0, 32'hF0F0_F0F0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
      // dividend below divisor over two digits
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
      // four digits of all ones by three
      '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
      // zero dividend over two digits
      '{32'h0000_0000, 32'h0000_0007, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (k = 0; k < NUM_ROWS; k++) begin
      typed_res = '{div_table[k].quotient, div_table[k].remainder, div_table[k].status, 1'b1};
      send_digit(div_table[k].dividend, div_table[k].divisor, div_table[k].last, 1'b0,
                 div_table[k].typed, typed_res);
    end

    // full store, closed by the store filling up
    wide_operand(1'b0);

    // random operands
    items = 0;
    while (items < 40) random_operand(items);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_multiword_restoring_divider_top: done, clean");
    end else begin
      $display("tb_multiword_restoring_divider_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("tb_multiword_restoring_divider_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
src/mrd_pkg.sv
src/mrd_datapath.sv
src/mrd_ctrl.sv
src/multiword_restoring_divider_top.sv
test/tb_multiword_restoring_divider_top.sv
